// ===== sv/rpn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, character codes and status codes for the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_MOD  = 8'h25;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_MUL,
        S_DIV,
        S_WB,
        S_FIN
    } state_t;

    // What one stack cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_UP,
        CELL_DOWN
    } cell_op_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) ||
               (c == CH_DIV) || (c == CH_MOD);
    endfunction

endpackage

`default_nettype wire

// ===== sv/rpn_char_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_char_if
// Character channel: one ASCII symbol and an end-of-expression mark per item.
// ----------------------------------------------------------------------------
interface rpn_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_result_if
// Result channel: evaluated value and status, one item per expression.
// ----------------------------------------------------------------------------
interface rpn_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_expression_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each character is accepted in S_IDLE, then takes its operator step in S_OP.
// + and - then write back in S_WB, * goes through S_MUL and S_WB, and / and %
// run the 32-step divider in S_DIV before S_WB. The final character then loads the
// result register in S_FIN. No character is taken until the one before it is through.
// Reset: asynchronous, active low; clears stack count, number, error and output valid.
// Stack contents are not reset; entries above the count are never read.
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_core
// Reverse Polish evaluator over a shifting chain of stack cells.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_core
    import rpn_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    rpn_char_if.sink    chars,
    rpn_result_if.source results
);

    state_t            state_reg, state_next;
    logic [7:0]        sym_reg, sym_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              in_num_reg, in_num_next;
    logic [2:0]        err_reg, err_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic [2:0]        out_status_reg, out_status_next;

    cell_op_t          cell_op [STACK_DEPTH];
    logic [DATA_W-1:0] cell_q  [STACK_DEPTH];
    logic [DATA_W-1:0] top_in;

    logic [DATA_W-1:0] tos, nos;
    logic [DATA_W-1:0] acc_ext;
    logic [DATA_W-1:0] push_val;
    logic              digit;
    logic              do_push;
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_q, div_r;
    logic [DATA_W-1:0] mag_a, mag_b;

    assign tos   = cell_q[0];
    assign nos   = cell_q[1];
    assign mag_a = nos[DATA_W-1] ? (-nos) : nos;
    assign mag_b = tos[DATA_W-1] ? (-tos) : tos;

    assign digit   = is_digit(chars.symbol);
    assign acc_ext = (acc_reg << 3) + (acc_reg << 1)
                   + DATA_W'(chars.symbol[3:0]);
    assign push_val = digit ? acc_ext : acc_reg;
    assign do_push  = (!digit || chars.last) && (digit || in_num_reg);

    assign chars.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;
        in_num_next     = in_num_reg;
        err_next        = err_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        div_start       = 1'b0;
        top_in          = res_reg;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            cell_op[i] = CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (chars.valid)
                begin
                    sym_next   = chars.symbol;
                    last_next  = chars.last;
                    state_next = S_OP;
                    if (err_reg == ST_OK)
                    begin
                        if (digit)
                        begin
                            acc_next    = acc_ext;
                            in_num_next = 1'b1;
                        end
                        if (do_push)
                        begin
                            acc_next    = '0;
                            in_num_next = 1'b0;
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_FULL;
                            end
                            else
                            begin
                                top_in = push_val;
                                for (int i = 0; i < STACK_DEPTH; i++)
                                begin
                                    cell_op[i] = CELL_UP;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            S_OP:
            begin
                state_next = last_reg ? S_FIN : S_IDLE;
                if ((err_reg == ST_OK) && is_operator(sym_reg))
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        err_next = ST_FEW;
                    end
                    else if (((sym_reg == CH_DIV) || (sym_reg == CH_MOD)) &&
                             (tos == '0))
                    begin
                        err_next = ST_DIVZERO;
                    end
                    else
                    begin
                        case (sym_reg)
                            CH_ADD:
                            begin
                                res_next   = nos + tos;
                                state_next = S_WB;
                            end
                            CH_SUB:
                            begin
                                res_next   = nos - tos;
                                state_next = S_WB;
                            end
                            CH_MUL:
                            begin
                                state_next = S_MUL;
                            end
                            default:
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                res_next   = nos * tos;
                state_next = S_WB;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (sym_reg == CH_DIV)
                    begin
                        res_next = (nos[DATA_W-1] != tos[DATA_W-1]) ? (-div_q) : div_q;
                    end
                    else
                    begin
                        res_next = nos[DATA_W-1] ? (-div_r) : div_r;
                    end
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // Replace the top two with the result: top takes it, the rest shift up
                top_in     = res_reg;
                cell_op[0] = CELL_UP;
                for (int i = 1; i < STACK_DEPTH; i++)
                begin
                    cell_op[i] = CELL_DOWN;
                end
                count_next = count_reg - 1'b1;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != ST_OK)
                    begin
                        out_value_next  = '0;
                        out_status_next = err_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        out_value_next  = '0;
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_value_next  = tos;
                        out_status_next = ST_OK;
                    end
                    count_next  = '0;
                    acc_next    = '0;
                    in_num_next = 1'b0;
                    err_next    = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            in_num_reg    <= 1'b0;
            err_reg       <= ST_OK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            in_num_reg    <= in_num_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        res_reg        <= res_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++)
        begin : g_cell
            logic [DATA_W-1:0] up_d;
            logic [DATA_W-1:0] down_d;
            if (g == 0)
            begin : g_top
                assign up_d = top_in;
            end
            else
            begin : g_mid
                assign up_d = cell_q[g-1];
            end
            if (g == STACK_DEPTH - 1)
            begin : g_bot
                assign down_d = cell_q[g];
            end
            else
            begin : g_inner
                assign down_d = cell_q[g+1];
            end
            rpn_cell u_cell (
                .clk       (clk),
                .op        (cell_op[g]),
                .up_data   (up_d),
                .down_data (down_d),
                .data      (cell_q[g])
            );
        end
    endgenerate

    rpn_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign results.valid  = out_valid_reg;
    assign results.value  = out_value_reg;
    assign results.status = out_status_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_cell
// One stack entry; shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
module rpn_cell
    import rpn_pkg::*;
(
    input  wire                 clk,
    input  wire cell_op_t       op,
    input  wire [DATA_W-1:0]    up_data,
    input  wire [DATA_W-1:0]    down_data,
    output logic [DATA_W-1:0]   data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        case (op)
            CELL_UP:   data_next = up_data;
            CELL_DOWN: data_next = down_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_divider
    import rpn_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire [DATA_W-1:0]    dividend,
    input  wire [DATA_W-1:0]    divisor,
    output logic                done,
    output logic [DATA_W-1:0]   quotient,
    output logic [DATA_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/rpn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the evaluator result channel.
// ----------------------------------------------------------------------------
module rpn_checker
    import rpn_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               result_valid,
    input wire               result_ready,
    input wire signed [31:0] result_value,
    input wire [2:0]         result_status
);

    // Status never carries a code outside the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_status <= ST_EMPTY))
        else $error("result status out of range");

    // Any error or empty result reports a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_status != ST_OK)) |-> (result_value == '0))
        else $error("nonzero value with error status");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(result_value) && $stable(result_status)))
        else $error("stalled result changed");

endmodule

bind rpn_expression_evaluator_core rpn_checker u_rpn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (results.valid),
    .result_ready  (results.ready),
    .result_value  (results.value),
    .result_status (results.status)
);

`default_nettype wire

// ===== verif/rpn_eval_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_eval_scoreboard
// Watches the character and result channels, evaluates each accepted
// expression on its own operand stack and compares every result item.
// ----------------------------------------------------------------------------
module rpn_eval_scoreboard
    import rpn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rpn_char_if   chars,
    rpn_result_if results,
    output int    fail_count,
    output int    pending_count
);

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
    } evaluation_t;

    logic [31:0] operand_stack [STACK_DEPTH];
    int          operand_depth = 0;
    logic [31:0] number_acc    = '0;
    logic        number_open   = 1'b0;
    logic [2:0]  first_error   = ST_OK;
    evaluation_t awaited_evaluations [$];

    initial fail_count = 0;

    task automatic clear_evaluator();
        operand_depth = 0;
        number_acc    = '0;
        number_open   = 1'b0;
        first_error   = ST_OK;
    endtask

    task automatic raise_error(input logic [2:0] code);
        if (first_error == ST_OK)
            first_error = code;
    endtask

    task automatic push_operand(input logic [31:0] v);
        if (operand_depth >= STACK_DEPTH)
        begin
            raise_error(ST_FULL);
            return;
        end
        operand_stack[operand_depth] = v;
        operand_depth++;
    endtask

    task automatic apply_operator(input logic [7:0] op);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        if (operand_depth < 2)
        begin
            raise_error(ST_FEW);
            return;
        end
        b = operand_stack[operand_depth - 1];
        a = operand_stack[operand_depth - 2];
        if ((op == CH_DIV || op == CH_MOD) && b == 32'd0)
        begin
            raise_error(ST_DIVZERO);
            return;
        end
        mag_a = a[31] ? 32'd0 - a : a;
        mag_b = b[31] ? 32'd0 - b : b;
        case (op)
            CH_ADD: r = a + b;
            CH_SUB: r = a - b;
            CH_MUL: r = a * b;
            CH_DIV:
            begin
                // truncate toward zero; sign follows the operand signs
                r = mag_a / mag_b;
                if (a[31] != b[31])
                    r = 32'd0 - r;
            end
            default:
            begin
                // remainder takes the sign of the dividend
                r = mag_a % mag_b;
                if (a[31])
                    r = 32'd0 - r;
            end
        endcase
        operand_depth--;
        operand_stack[operand_depth - 1] = r;
    endtask

    task automatic evaluate_symbol(input logic [7:0] sym, input logic fin);
        logic        is_num;
        evaluation_t outcome;
        is_num = (sym >= CH_ZERO) && (sym <= CH_NINE);
        if (first_error == ST_OK)
        begin
            if (is_num)
            begin
                number_acc  = number_acc * 32'd10 + 32'(sym - CH_ZERO);
                number_open = 1'b1;
            end
            if ((!is_num || fin) && number_open)
            begin
                push_operand(number_acc);
                number_acc  = '0;
                number_open = 1'b0;
            end
            if (first_error == ST_OK)
            begin
                case (sym)
                    CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD: apply_operator(sym);
                    default: ;
                endcase
            end
        end
        if (fin)
        begin
            outcome.value = '0;
            if (first_error != ST_OK)
                outcome.status = first_error;
            else if (operand_depth == 0)
                outcome.status = ST_EMPTY;
            else
            begin
                outcome.value  = operand_stack[operand_depth - 1];
                outcome.status = ST_OK;
            end
            awaited_evaluations.push_back(outcome);
            clear_evaluator();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sample_channels
        evaluation_t want;
        if (!rst_n)
        begin
            clear_evaluator();
            awaited_evaluations.delete();
            pending_count = 0;
        end
        else
        begin
            // results first: an item accepted at this edge cannot finish at it
            if (results.valid && results.ready)
            begin
                if (awaited_evaluations.size() == 0)
                begin
                    $error("unexpected result: value %0d, status %0d",
                           results.value, results.status);
                    fail_count++;
                end
                else
                begin
                    want = awaited_evaluations.pop_front();
                    if (results.value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), results.value);
                        fail_count++;
                    end
                    if (results.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, results.status);
                        fail_count++;
                    end
                end
            end
            if (chars.valid && chars.ready)
                evaluate_symbol(chars.symbol, chars.last);
            pending_count = awaited_evaluations.size();
        end
    end

endmodule

// ===== verif/tb_rpn_expression_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_expression_evaluator_core
// Feeds the evaluator directed and random character streams with random
// gaps on both channels and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_rpn_expression_evaluator_core;
    import rpn_pkg::*;

    localparam int         ITEM_TARGET    = 1400;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         LONG_HOLD      = 400;
    localparam logic [7:0] CH_SPACE       = 8'h20;

    logic       clk = 1'b0;
    logic       rst_n;
    int         fail_count;
    int         pending_count;
    int         symbols_sent;
    int         idle_cycles = 0;
    bit         sender_calm;
    logic [7:0] expr_q [$];

    rpn_char_if   chars_if ();
    rpn_result_if results_if ();

    rpn_expression_evaluator_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    rpn_eval_scoreboard i_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars         (chars_if),
        .results       (results_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #2 clk = ~clk;

    // Mostly no gap, else short gaps and a few long ones; none at all in a calm stretch
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(4))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_MOD;
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        logic [7:0] sep;
        if ($urandom_range(9) < 7)
            return CH_SPACE;
        do
            sep = 8'($urandom_range(255));
        while ((sep >= CH_ZERO && sep <= CH_NINE) || sep == CH_ADD || sep == CH_SUB ||
               sep == CH_MUL || sep == CH_DIV || sep == CH_MOD);
        return sep;
    endfunction

    task automatic add_literal(input string s);
        foreach (s[i])
            expr_q.push_back(s[i]);
    endtask

    task automatic add_number(input int ndigits);
        for (int i = 0; i < ndigits; i++)
            expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic add_random_number();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            add_number($urandom_range(3, 1));
        else if (roll < 88)
            add_number($urandom_range(9, 4));
        else
            add_number($urandom_range(13, 10));
    endtask

    // Valid RPN with random numbers; sometimes leaves extra operands behind
    task automatic build_well_formed();
        int operands;
        int depth;
        bit after_number;
        operands     = $urandom_range(6, 1);
        depth        = 0;
        after_number = 1'b0;
        if ($urandom_range(9) == 0)
            expr_q.push_back(pick_separator());
        while (operands > 0 || depth > 1)
        begin
            if (operands > 0 && (depth < 2 || $urandom_range(1)))
            begin
                if (after_number)
                    expr_q.push_back(pick_separator());
                add_random_number();
                after_number = 1'b1;
                operands--;
                depth++;
            end
            else
            begin
                if (after_number && $urandom_range(1))
                    expr_q.push_back(pick_separator());
                expr_q.push_back(pick_operator());
                after_number = 1'b0;
                depth--;
                if (operands == 0 && depth > 1 && $urandom_range(4) == 0)
                    break;
            end
        end
        if ($urandom_range(3) == 0)
            expr_q.push_back(pick_separator());
    endtask

    task automatic build_corner(input int kind);
        int n;
        case (kind)
            0: add_literal("2147483648 0 1-/");
            1: add_literal("2147483648 0 1-%");
            2:
            begin
                // overflow the stack, then keep going
                n = $urandom_range(20, 17);
                for (int i = 0; i < n; i++)
                begin
                    add_number($urandom_range(2, 1));
                    expr_q.push_back(CH_SPACE);
                end
                add_literal("++");
            end
            3:
            begin
                add_number($urandom_range(20, 11));
                expr_q.push_back(pick_separator());
                add_number($urandom_range(3, 1));
                expr_q.push_back(pick_operator());
            end
            4:
            begin
                add_random_number();
                add_literal(" 0");
                expr_q.push_back($urandom_range(1) ? CH_DIV : CH_MOD);
                add_literal(" 5 6+");
            end
            default: add_literal("5 3-*7+");
        endcase
    endtask

    task automatic build_noise();
        int n;
        int roll;
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(9);
            if (roll < 4)
                add_number(1);
            else if (roll < 6)
                expr_q.push_back(pick_operator());
            else
                expr_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_symbol(input logic [7:0] sym, input logic fin);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid  <= 1'b1;
        chars_if.symbol <= sym;
        chars_if.last   <= fin;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        symbols_sent++;
        @(negedge clk);
    endtask

    task automatic send_expression();
        sender_calm = ($urandom_range(4) == 0);
        foreach (expr_q[i])
            send_symbol(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
    endtask

    initial
    begin
        int roll;
        int corner_no;
        corner_no         = 0;
        symbols_sent      = 0;
        sender_calm       = 1'b0;
        rst_n             = 1'b0;
        chars_if.valid    = 1'b0;
        chars_if.symbol   = '0;
        chars_if.last     = 1'b0;
        results_if.ready  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone characters: empty stack at both code extremes, digit, operator
        expr_q.push_back(8'h00);
        send_expression();
        expr_q.push_back(8'hFF);
        send_expression();
        add_literal("7");
        send_expression();
        add_literal("+");
        send_expression();
        // every operator in one expression, then an error with trailing input
        add_literal("7 3%6 5*-2/1+");
        send_expression();
        add_literal("9 0/3+");
        send_expression();

        while (symbols_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(99);
            if (roll < 68)
                build_well_formed();
            else if (roll < 80)
            begin
                build_corner(corner_no % 6);
                corner_no++;
            end
            else
                build_noise();
            send_expression();
        end
        chars_if.valid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, calm stretches and periodic long hold-offs
    initial
    begin
        int cycle_no;
        int stall_left;
        int stretch_left;
        bit receiver_calm;
        cycle_no      = 0;
        stall_left    = 0;
        stretch_left  = 0;
        receiver_calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (stretch_left == 0)
            begin
                receiver_calm = ($urandom_range(3) == 0);
                stretch_left  = $urandom_range(300, 50);
            end
            stretch_left--;
            if (cycle_no == 800 || cycle_no % 25000 == 0)
                stall_left = LONG_HOLD;
            if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results_if.ready <= 1'b1;
                stall_left = pick_gap(receiver_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars_if.valid && chars_if.ready) ||
                (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
